/* sv/ir2c_pkg.sv */
// Package for the address range to prefix block decomposer.
// Holds the beat types, the queue status struct, the walker state enum and fixed sizes.
// No dependencies.
`default_nettype none

package ir2c_pkg;

    localparam int ADDR_BITS   = 32;
    localparam int PREFIX_BITS = 6;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [ADDR_BITS-1:0] range_start;
        logic [ADDR_BITS-1:0] range_end;
    } range_item_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]   block_address;
        logic [PREFIX_BITS-1:0] prefix_length;
        logic                   last_block;
    } block_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        WALK_IDLE,
        WALK_SPAN,
        WALK_EMIT
    } walk_state_t;

endpackage : ir2c_pkg

`default_nettype wire

/* sv/ir2c_front.sv */
// Front end of the decomposer: masks a request beat and drops empty ranges.
// Depends on ir2c_pkg; feeds ir2c_queue.
`default_nettype none

module ir2c_front
    import ir2c_pkg::*;
#(
    parameter int ADDR_WIDTH = 32
)
(
    input  wire logic        start,
    input  wire range_item_t request,
    input  wire q_status_t   q_status,
    output logic             busy,
    output logic             push,
    output range_item_t      push_data
);

    logic [ADDR_BITS-1:0] start_masked;
    logic [ADDR_BITS-1:0] end_masked;

    // Drop address bits above the configured width.
    assign start_masked = ADDR_BITS'(request.range_start[ADDR_WIDTH-1:0]);
    assign end_masked   = ADDR_BITS'(request.range_end[ADDR_WIDTH-1:0]);

    assign busy = q_status.full;

    // Queue only ranges that hold at least one address.
    assign push = start && !q_status.full && !(start_masked > end_masked);

    assign push_data.range_start = start_masked;
    assign push_data.range_end   = end_masked;

endmodule : ir2c_front

`default_nettype wire

/* sv/ir2c_queue.sv */
// Short FIFO between the front end and the walker.
// Depends on ir2c_pkg.
`default_nettype none

module ir2c_queue
    import ir2c_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire range_item_t push_data,
    input  wire logic        pop,
    output range_item_t      head,
    output q_status_t        q_status
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    range_item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]     wr_ptr_reg;
    logic [PTR_BITS-1:0]     wr_ptr_next;
    logic [PTR_BITS-1:0]     rd_ptr_reg;
    logic [PTR_BITS-1:0]     rd_ptr_next;
    logic [CNT_BITS-1:0]     count_reg;
    logic [CNT_BITS-1:0]     count_next;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        if (p == PTR_BITS'(QUEUE_DEPTH - 1))
            return '0;
        return p + PTR_BITS'(1);
    endfunction

    assign q_status.full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule : ir2c_queue

`default_nettype wire

/* sv/ir2c_walker.sv */
// Back end of the decomposer: walks one range and emits one prefix block per pass through its span and emit states.
// Depends on ir2c_pkg; pulls ranges from ir2c_queue.
`default_nettype none

module ir2c_walker
    import ir2c_pkg::*;
#(
    parameter int ADDR_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire range_item_t head,
    input  wire q_status_t   q_status,
    output logic             pop,
    output logic             result_valid,
    output block_item_t      result
);

    localparam int W        = ADDR_WIDTH;
    localparam int IDX_BITS = $clog2(W + 1);

    walk_state_t          state_reg;
    walk_state_t          state_next;
    logic [W-1:0]         cur_reg;
    logic [W-1:0]         cur_next;
    logic [W-1:0]         lim_reg;
    logic [W-1:0]         lim_next;
    logic [W:0]           span_reg;
    logic [W:0]           span_next;
    logic [W-1:0]         low_reg;
    logic [W-1:0]         low_next;
    logic                 valid_reg;
    logic                 valid_next;
    block_item_t          result_reg;
    block_item_t          result_next;

    logic [W:0]           span_smear;
    logic [W:0]           span_msb;
    logic [W:0]           low_ext;
    logic [W:0]           size_onehot;
    logic [IDX_BITS-1:0]  size_log2;
    logic                 is_last;

    // Fill every bit below the leading one.
    function automatic logic [W:0] smear(input logic [W:0] v);
        logic [W:0] acc;
        acc = v;
        for (int j = 1; j <= W; j = j * 2)
            acc = acc | (acc >> j);
        return acc;
    endfunction

    function automatic logic [IDX_BITS-1:0] onehot_index(input logic [W:0] v);
        logic [IDX_BITS-1:0] idx;
        idx = '0;
        for (int i = 0; i <= W; i++)
            if (v[i])
                idx = idx | IDX_BITS'(i);
        return idx;
    endfunction

    // Block size: the smaller of the cursor alignment and the largest power of two in the span.
    always_comb
    begin
        span_smear  = smear(span_reg);
        span_msb    = span_smear & ~(span_smear >> 1);
        low_ext     = {1'b0, low_reg};
        size_onehot = ((low_ext & span_smear) != '0) ? low_ext : span_msb;
        size_log2   = onehot_index(size_onehot);
        is_last     = (size_onehot == span_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        lim_next    = lim_reg;
        span_next   = span_reg;
        low_next    = low_reg;
        valid_next  = 1'b0;
        result_next = result_reg;
        pop         = 1'b0;
        case (state_reg)
            WALK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    cur_next   = head.range_start[W-1:0];
                    lim_next   = head.range_end[W-1:0];
                    state_next = WALK_SPAN;
                end
            end
            WALK_SPAN:
            begin
                span_next  = {1'b0, lim_reg} - {1'b0, cur_reg} + (W+1)'(1);
                low_next   = cur_reg & (~cur_reg + W'(1));
                state_next = WALK_EMIT;
            end
            WALK_EMIT:
            begin
                valid_next                = 1'b1;
                result_next.block_address = ADDR_BITS'(cur_reg);
                result_next.prefix_length = PREFIX_BITS'(W) - PREFIX_BITS'(size_log2);
                result_next.last_block    = is_last;
                // Advance past the block; the top block wraps the cursor to zero.
                cur_next                  = cur_reg + size_onehot[W-1:0];
                state_next                = is_last ? WALK_IDLE : WALK_SPAN;
            end
            default:
            begin
                state_next = WALK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WALK_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        lim_reg    <= lim_next;
        span_reg   <= span_next;
        low_reg    <= low_next;
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule : ir2c_walker

`default_nettype wire

/* sv/ipv4_range_to_cidr_blocks.sv */
// Top level of the inclusive address range to prefix block decomposer.
// Depends on ir2c_pkg, ir2c_front, ir2c_queue and ir2c_walker.
//
//   channel   direction  handshake                   beat
//   request   in         start high, busy low        range_item_t  (range_start, range_end)
//   result    out        result_valid, one cycle     block_item_t  (block_address,
//                                                                   prefix_length, last_block)
//
// A range leaves the queue in the idle state; each block then takes a span/alignment step
// and a size select and emit step, as the walker alternates its span and emit states.
// A two-entry queue takes new ranges while a walk runs; busy is high only while it is full.
// A range whose start lies above its end is dropped at the front and gives no beat.
// Reset clears the queue pointers, the walker state and the result strobe.
// Results cannot be stalled: each beat is on the result ports for exactly one cycle.
`default_nettype none

module ipv4_range_to_cidr_blocks
    import ir2c_pkg::*;
#(
    parameter int ADDR_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire range_item_t request,
    output logic             busy,
    output logic             result_valid,
    output block_item_t      result
);

    q_status_t   q_status;
    logic        push;
    range_item_t push_data;
    logic        pop;
    range_item_t head;

    // Front: mask, classify, and push non-empty ranges.
    ir2c_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .start     (start),
        .request   (request),
        .q_status  (q_status),
        .busy      (busy),
        .push      (push),
        .push_data (push_data)
    );

    // Queue: hold ranges until the walker is free.
    ir2c_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    // Back: walk one range at a time and emit its blocks.
    ir2c_walker #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

    // Never push into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_status.full)
        else $error("push while queue full");

    // Never pop an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty)
        else $error("pop while queue empty");

    // Result beats never come in consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |=> !result_valid)
        else $error("result beats in consecutive cycles");

    // A whole-space block starts at zero and ends the walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.prefix_length == '0)
            |-> (result.block_address == '0 && result.last_block))
        else $error("prefix zero block not at address zero or not last");

endmodule : ipv4_range_to_cidr_blocks

`default_nettype wire
